// ===== rtl/core/jssd_pkg.sv =====
// shared types, codes and coil table for the joystick half-step stepper driver
package jssd_pkg;

	localparam int unsigned THR_W   = 10;
	localparam int unsigned LEN_W   = 16;
	localparam int unsigned COIL_W  = 4;
	localparam int unsigned DIR_W   = 2;
	localparam int unsigned PHASE_W = 3;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [THR_W-1:0] HIGH_THR_RST = 10'd600;
	localparam logic [THR_W-1:0] LOW_THR_RST  = 10'd400;
	localparam logic [LEN_W-1:0] MOVE_LEN_RST = 16'd227;

	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MOVE_LEN = 2'd2;

	localparam logic FUNC_STICK = 1'b0;
	localparam logic FUNC_TICK  = 1'b1;

	localparam logic [DIR_W-1:0] DIR_CCW  = 2'd0;
	localparam logic [DIR_W-1:0] DIR_CW   = 2'd1;
	localparam logic [DIR_W-1:0] DIR_NONE = 2'd2;

	typedef struct packed {
		logic             func;
		logic [THR_W-1:0] stick_sample;
	} in_t;

	typedef struct packed {
		logic [COIL_W-1:0] coil_pattern;
		logic [DIR_W-1:0]  direction;
		logic [LEN_W-1:0]  steps_done;
		logic              moving;
	} out_t;

	typedef struct packed {
		logic [THR_W-1:0] high_threshold;
		logic [THR_W-1:0] low_threshold;
		logic [LEN_W-1:0] move_length;
	} cfg_t;

	function automatic logic [COIL_W-1:0] coil_of(input logic [PHASE_W-1:0] ph);
		logic [COIL_W-1:0] c;
		begin
			case (ph)
				3'd0:    c = 4'h1;
				3'd1:    c = 4'h3;
				3'd2:    c = 4'h2;
				3'd3:    c = 4'h6;
				3'd4:    c = 4'h4;
				3'd5:    c = 4'hC;
				3'd6:    c = 4'h8;
				default: c = 4'h9;
			endcase
			return c;
		end
	endfunction

endpackage

// ===== rtl/core/joystick_stepper_half_step_driver.sv =====
// top level of the joystick half-step stepper driver: registers, handshakes, engine
//
//   channel | signals                         | moves
//   --------+---------------------------------+------------------------------
//   in      | in_valid, in_ready, in_data     | one request: sample or tick
//   out     | out_valid, out_ready, out_data  | one result per request
//   cfg     | cfg_wr_en, cfg_index, cfg_data  | register write, no wait
//
// a request enters the input register at its accepting edge, the engine updates
// state and the result register loads when the request advances, which needs the
// result register empty or being read: one request per cycle throughput unless stalled
// when the result register is held, one more request is taken into the input
// register and waits there
// reset restores thresholds 600 and 400, move length 227, no direction, phase A
module joystick_stepper_half_step_driver (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  jssd_pkg::in_t                      in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output jssd_pkg::out_t                     out_data,
	input  logic                               cfg_wr_en,
	input  logic [jssd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [jssd_pkg::LEN_W-1:0]         cfg_data
);
	import jssd_pkg::*;

	logic  valid_s1;
	in_t   req_s1;
	logic  advance;
	cfg_t  cfg_q;
	out_t  res;
	logic  out_valid_q;
	out_t  out_data_q;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.high_threshold <= HIGH_THR_RST;
			cfg_q.low_threshold  <= LOW_THR_RST;
			cfg_q.move_length    <= MOVE_LEN_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_HIGH_THR: cfg_q.high_threshold <= cfg_data[THR_W-1:0];
				CFG_LOW_THR:  cfg_q.low_threshold  <= cfg_data[THR_W-1:0];
				CFG_MOVE_LEN: cfg_q.move_length    <= cfg_data;
				default: ;
			endcase
		end
	end

	jssd_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.req     (req_s1),
		.cfg     (cfg_q),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== rtl/core/jssd_engine.sv =====
// joystick mode machine, step counter and phase sequencer with result logic
module jssd_engine (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  jssd_pkg::in_t  req,
	input  jssd_pkg::cfg_t cfg,
	output jssd_pkg::out_t res
);
	import jssd_pkg::*;

	typedef enum logic [2:0] {
		MODE_IDLE   = 3'd0,
		MODE_RIGHT  = 3'd1,
		MODE_LEFT   = 3'd2,
		MODE_CENTRE = 3'd3,
		MODE_WAIT   = 3'd4
	} mode_t;

	mode_t              mode_q, mode_n;
	logic [DIR_W-1:0]   dir_q, dir_n;
	logic [LEN_W-1:0]   tgt_q, tgt_n;
	logic [LEN_W-1:0]   cnt_q, cnt_n;
	logic [PHASE_W-1:0] ph_q, ph_n;

	always_comb begin
		mode_n = mode_q;
		dir_n  = dir_q;
		tgt_n  = tgt_q;
		cnt_n  = cnt_q;
		ph_n   = ph_q;
		if (req.func == FUNC_STICK) begin
			unique case (mode_q)
				MODE_IDLE: begin
					if (req.stick_sample > cfg.high_threshold) begin
						mode_n = MODE_RIGHT;
					end else if (req.stick_sample < cfg.low_threshold) begin
						mode_n = MODE_LEFT;
					end
				end
				MODE_RIGHT, MODE_LEFT: mode_n = MODE_WAIT;
				MODE_WAIT: begin
					if (req.stick_sample > cfg.low_threshold &&
							req.stick_sample < cfg.high_threshold) begin
						mode_n = MODE_CENTRE;
					end
				end
				MODE_CENTRE: mode_n = MODE_IDLE;
				default: mode_n = mode_q;
			endcase
			case (mode_n)
				MODE_RIGHT: begin
					dir_n = DIR_CW;
					tgt_n = cfg.move_length;
				end
				MODE_LEFT: begin
					dir_n = DIR_CCW;
					tgt_n = cfg.move_length;
				end
				MODE_CENTRE: begin
					if (dir_q == DIR_CW) begin
						dir_n = DIR_CCW;
						tgt_n = cfg.move_length;
					end else if (dir_q == DIR_CCW) begin
						dir_n = DIR_CW;
						tgt_n = cfg.move_length;
					end
				end
				default: ;
			endcase
		end else if (dir_q == DIR_CW || dir_q == DIR_CCW) begin
			if (cnt_q != tgt_q) begin
				cnt_n = cnt_q + 16'd1;
				ph_n  = (dir_q == DIR_CW) ? ph_q + 3'd1 : ph_q - 3'd1;
			end else begin
				cnt_n = '0;
				tgt_n = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			dir_q  <= DIR_NONE;
			tgt_q  <= '0;
			cnt_q  <= '0;
			ph_q   <= '0;
		end else if (advance) begin
			mode_q <= mode_n;
			dir_q  <= dir_n;
			tgt_q  <= tgt_n;
			cnt_q  <= cnt_n;
			ph_q   <= ph_n;
		end
	end

	assign res.coil_pattern = coil_of(ph_n);
	assign res.direction    = dir_n;
	assign res.steps_done   = cnt_n;
	assign res.moving       = (cnt_n != tgt_n);

endmodule

// ===== rtl/core/jssd_checker.sv =====
// port-level assertions for the joystick half-step stepper driver and their bind
module jssd_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           out_valid,
	input logic           out_ready,
	input jssd_pkg::out_t out_data
);
	import jssd_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_dir_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.direction == DIR_CCW || out_data.direction == DIR_CW ||
			out_data.direction == DIR_NONE))
		else $error("bad direction code");

	a_coil_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.coil_pattern == 4'h1 || out_data.coil_pattern == 4'h3 ||
			out_data.coil_pattern == 4'h2 || out_data.coil_pattern == 4'h6 ||
			out_data.coil_pattern == 4'h4 || out_data.coil_pattern == 4'hC ||
			out_data.coil_pattern == 4'h8 || out_data.coil_pattern == 4'h9))
		else $error("coil pattern is not a half-step phase");

	a_hold_no_dir: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.direction == DIR_NONE |->
			out_data.coil_pattern == 4'h1 && out_data.steps_done == '0)
		else $error("motor moved before a direction was set");

endmodule

bind joystick_stepper_half_step_driver jssd_checker u_jssd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

// ===== tb/sv/jssd_motion_check.sv =====
// checker for the joystick half-step stepper driver: predicts each result and compares it
module jssd_motion_check (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  jssd_pkg::in_t                  in_data,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  jssd_pkg::out_t                 out_data,
	input  logic                           cfg_wr_en,
	input  logic [jssd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [jssd_pkg::LEN_W-1:0]     cfg_data,
	output int unsigned                    mismatches,
	output int unsigned                    results_due
);
	timeunit 1ns;
	timeprecision 1ps;

	import jssd_pkg::*;

	typedef enum logic [2:0] {
		STICK_IDLE   = 3'd0,
		STICK_RIGHT  = 3'd1,
		STICK_LEFT   = 3'd2,
		STICK_CENTRE = 3'd3,
		STICK_WAIT   = 3'd4
	} stick_mode_e;

	// half-step coil codes, phase 0 in the low nibble
	localparam logic [8*COIL_W-1:0] COIL_SEQ = 32'h98C4_6231;

	stick_mode_e          mode;
	logic [DIR_W-1:0]     turn_dir;
	logic [LEN_W-1:0]     target;
	logic [LEN_W-1:0]     count;
	logic [PHASE_W-1:0]   phase;
	cfg_t                 regs;
	out_t                 due_results[$];
	out_t                 want;

	function automatic out_t step_motor(input in_t req);
		out_t                res;
		logic [THR_W-1:0]    s;
		s = req.stick_sample;
		if (req.func == FUNC_STICK) begin
			case (mode)
				STICK_IDLE: begin
					if (s > regs.high_threshold) mode = STICK_RIGHT;
					else if (s < regs.low_threshold) mode = STICK_LEFT;
				end
				STICK_RIGHT, STICK_LEFT: mode = STICK_WAIT;
				STICK_WAIT: begin
					if (s > regs.low_threshold && s < regs.high_threshold) mode = STICK_CENTRE;
				end
				STICK_CENTRE: mode = STICK_IDLE;
				default: ;
			endcase
			case (mode)
				STICK_RIGHT: begin
					turn_dir = DIR_CW;
					target = regs.move_length;
				end
				STICK_LEFT: begin
					turn_dir = DIR_CCW;
					target = regs.move_length;
				end
				STICK_CENTRE: begin
					// reverse only once a direction exists
					if (turn_dir == DIR_CW) begin
						turn_dir = DIR_CCW;
						target = regs.move_length;
					end else if (turn_dir == DIR_CCW) begin
						turn_dir = DIR_CW;
						target = regs.move_length;
					end
				end
				default: ;
			endcase
		end else if (turn_dir == DIR_CW || turn_dir == DIR_CCW) begin
			if (count != target) begin
				count = count + 16'd1;
				phase = (turn_dir == DIR_CW) ? phase + 3'd1 : phase - 3'd1;
			end else begin
				count = '0;
				target = '0;
			end
		end
		res.coil_pattern = COIL_SEQ[{phase, 2'b00} +: COIL_W];
		res.direction    = turn_dir;
		res.steps_done   = count;
		res.moving       = (count != target);
		return res;
	endfunction

	task automatic check_field(input string field, input logic [31:0] exp_val, got_val);
		if (exp_val !== got_val) begin
			mismatches++;
			$display("%0t: %s expected %0d, got %0d", $time, field, exp_val, got_val);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode        = STICK_IDLE;
			turn_dir    = DIR_NONE;
			target      = '0;
			count       = '0;
			phase       = '0;
			regs        = '{HIGH_THR_RST, LOW_THR_RST, MOVE_LEN_RST};
			mismatches  = 0;
			results_due = 0;
			due_results.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					mismatches++;
					$display("%0t: result with no request pending, expected nothing, got %h",
						$time, out_data);
				end else begin
					want = due_results.pop_front();
					check_field("coil_pattern", 32'(want.coil_pattern),
						32'(out_data.coil_pattern));
					check_field("direction", 32'(want.direction), 32'(out_data.direction));
					check_field("steps_done", 32'(want.steps_done), 32'(out_data.steps_done));
					check_field("moving", 32'(want.moving), 32'(out_data.moving));
				end
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_HIGH_THR: regs.high_threshold = cfg_data[THR_W-1:0];
					CFG_LOW_THR:  regs.low_threshold  = cfg_data[THR_W-1:0];
					CFG_MOVE_LEN: regs.move_length    = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) due_results.push_back(step_motor(in_data));
			results_due = due_results.size();
		end
	end

endmodule

// ===== tb/sv/joystick_stepper_half_step_driver_test.sv =====
// testbench top for the joystick half-step stepper driver: stimulus, flow control and verdict
module joystick_stepper_half_step_driver_test;
	timeunit 1ns;
	timeprecision 1ps;

	import jssd_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;
	localparam int unsigned          CYCLE_LIMIT = 1_000_000;
	localparam int unsigned          HOLD_CYCLES = 80;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	in_t                  in_data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_t                 out_data;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [LEN_W-1:0]     cfg_data = '0;

	int unsigned          mismatches;
	int unsigned          results_due;
	int unsigned          cycle_count = 0;
	int unsigned          sent = 0;

	logic [THR_W-1:0]     hi_thr = HIGH_THR_RST;
	logic [THR_W-1:0]     lo_thr = LOW_THR_RST;
	logic [LEN_W-1:0]     mv_len = MOVE_LEN_RST;
	bit                   tx_quiet = 1'b0;
	bit                   rx_quiet = 1'b0;
	bit                   rx_hold = 1'b0;

	joystick_stepper_half_step_driver u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	jssd_motion_check u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.results_due (results_due)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// result side: random stalls, quiet stretches, one long hold on request
	initial begin
		int unsigned stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (rx_hold) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_hold = 1'b0;
			end
			stall = rx_quiet ? 0 : $urandom_range(0, 12);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send_request(input logic f, input logic [THR_W-1:0] s);
		int unsigned gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 12);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{func: f, stick_sample: s};
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	task automatic stick_request(input logic [THR_W-1:0] s);
		send_request(FUNC_STICK, s);
	endtask

	task automatic tick_request();
		send_request(FUNC_TICK, THR_W'($urandom_range(0, 1023)));
	endtask

	task automatic tick_run();
		int unsigned n;
		n = $urandom_range(0, (mv_len > 20) ? 20 : int'(mv_len) + 3);
		repeat (n) tick_request();
	endtask

	function automatic logic [THR_W-1:0] right_sample();
		if (hi_thr == '1) return THR_W'($urandom_range(0, 1023));
		if ($urandom_range(0, 3) == 0) return THR_W'(int'(hi_thr) + 1);
		return THR_W'($urandom_range(int'(hi_thr) + 1, 1023));
	endfunction

	function automatic logic [THR_W-1:0] left_sample();
		if (lo_thr == '0) return THR_W'($urandom_range(0, 1023));
		if ($urandom_range(0, 3) == 0) return THR_W'(int'(lo_thr) - 1);
		return THR_W'($urandom_range(0, int'(lo_thr) - 1));
	endfunction

	function automatic logic [THR_W-1:0] centre_sample();
		if (int'(hi_thr) <= int'(lo_thr) + 1) return THR_W'($urandom_range(0, 1023));
		return THR_W'($urandom_range(int'(lo_thr) + 1, int'(hi_thr) - 1));
	endfunction

	// stop offering requests and wait until every result is back
	task automatic settle();
		in_valid <= 1'b0;
		do @(negedge clk); while (results_due != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_HIGH_THR: hi_thr = val[THR_W-1:0];
			CFG_LOW_THR:  lo_thr = val[THR_W-1:0];
			CFG_MOVE_LEN: mv_len = val;
			default: ;
		endcase
	endtask

	// unused upper data bits are randomized on threshold writes
	task automatic configure(input logic [THR_W-1:0] h, l, input logic [LEN_W-1:0] m);
		settle();
		set_reg(CFG_HIGH_THR, LEN_W'(($urandom_range(0, 63) << THR_W) | h));
		set_reg(CFG_LOW_THR, LEN_W'(($urandom_range(0, 63) << THR_W) | l));
		set_reg(CFG_MOVE_LEN, m);
	endtask

	// mostly complete turn sequences with random timing, some random noise
	task automatic run_setting(input logic [THR_W-1:0] h, l, input logic [LEN_W-1:0] m,
			input int unsigned budget);
		int unsigned stop_at;
		configure(h, l, m);
		stop_at = sent + budget;
		while (sent < stop_at) begin
			tx_quiet = ($urandom_range(0, 4) == 0);
			rx_quiet = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 4) != 0) begin
				stick_request($urandom_range(0, 1) ? right_sample() : left_sample());
				tick_run();
				stick_request(THR_W'($urandom_range(0, 1023)));
				repeat ($urandom_range(0, 2)) stick_request(THR_W'($urandom_range(0, 1023)));
				tick_run();
				stick_request(centre_sample());
				tick_run();
				stick_request(THR_W'($urandom_range(0, 1023)));
			end else begin
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(0, 1)) tick_request();
					else stick_request(THR_W'($urandom_range(0, 1) ? $urandom_range(0, 1023)
						: ($urandom_range(0, 1) ? 1023 : 0)));
				end
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset thresholds: no direction, equal-to-threshold samples, turns and re-centres
		tick_request();
		stick_request(10'd600);
		stick_request(10'd400);
		stick_request(10'd1023);
		tick_request();
		tick_request();
		stick_request(10'd0);
		stick_request(10'd600);
		stick_request(10'd400);
		stick_request(10'd401);
		tick_request();
		stick_request(10'd599);
		stick_request(10'd0);
		stick_request(10'd1023);
		stick_request(10'd599);
		stick_request(10'd512);
		tick_request();
		tick_request();

		// receiver backs off while requests keep coming
		settle();
		tx_quiet = 1'b1;
		rx_hold  = 1'b1;
		repeat (30) begin
			if ($urandom_range(0, 1)) tick_request();
			else stick_request(THR_W'($urandom_range(0, 1023)));
		end
		tx_quiet = 1'b0;

		run_setting(10'd600, 10'd400, 16'd5, 160);
		run_setting(10'd1023, 10'd0, 16'd0, 80);
		run_setting(10'd0, 10'd1023, 16'd3, 100);
		run_setting(10'd700, 10'd300, 16'd12, 170);
		run_setting(10'd513, 10'd511, 16'd1, 130);
		run_setting(10'd900, 10'd100, 16'hFFFF, 80);
		run_setting(10'd650, 10'd350, 16'd8, 170);

		// long move: count climbs well past the short lengths
		configure(10'd600, 10'd400, 16'hFFFF);
		tx_quiet = 1'b1;
		rx_quiet = 1'b1;
		repeat (4) stick_request(10'd500);
		stick_request(10'd1023);
		repeat (40) tick_request();

		// target shrinks below the count mid-move
		configure(10'd600, 10'd400, 16'd10);
		repeat (4) stick_request(10'd500);
		stick_request(10'd0);
		repeat (8) tick_request();
		configure(10'd600, 10'd400, 16'd2);
		tx_quiet = 1'b1;
		stick_request(10'd1023);
		stick_request(10'd500);
		repeat (12) tick_request();

		settle();
		set_reg(CFG_UNUSED, LEN_W'($urandom_range(0, 65535)));
		run_setting(10'd600, 10'd400, 16'd4, 120);

		settle();
		if (mismatches == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end

endmodule
